/* src/srs_pkg.sv */
// ----------------------------------------------------------------------------
// srs_pkg
// widths, register indexes and pipeline payload types of the spotlight
// radiance sampler
// ----------------------------------------------------------------------------
package srs_pkg;

    // stream and configuration widths
    localparam int POS_W       = 24;
    localparam int IN_TDATA_W  = 3 * POS_W;
    localparam int DIR_W       = 16;
    localparam int RAD_W       = 32;
    localparam int OUT_TDATA_W = 3 * DIR_W + 3 * RAD_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;
    localparam int COS_W       = 16;
    localparam int CH_W        = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_POS_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_POS_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_POS_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPOT_AXIS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY_RGB   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_TOTAL_WIDTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_FALLOFF     = 3'd6;

    // internal datapath widths
    localparam int D_W      = POS_W + 1;
    localparam int MAG_W    = POS_W;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int DIST_W   = SQ_W + 2;
    localparam int LEN_W    = 31;
    localparam int SQ_STEPS = LEN_W;
    localparam int SQ_REM_W = LEN_W + 2;
    localparam int DQ_W     = 15;
    localparam int DNUM_W   = MAG_W + 21;
    localparam int C_W      = 21;
    localparam int FQ_W     = 17;
    localparam int FNUM_W   = 32;
    localparam int FDEN_W   = 16;
    localparam int RNUM_W   = 51;

    localparam logic [DIR_W-1:0] DIR_ONE  = 16'd16384;
    localparam logic [FQ_W-1:0]  FALL_ONE = 17'd65536;

    // geometry carried through the square root
    typedef struct packed {
        logic [DIST_W-1:0]     dist2;
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
    } t_geo;

    // carried through the direction dividers
    typedef struct packed {
        logic [DIST_W-1:0] dist2;
        logic [2:0]        neg;
        logic [2:0]        sat;
    } t_dsd;

    // carried through the falloff divider
    typedef struct packed {
        logic [DIST_W-1:0]     dist2;
        logic [2:0][DIR_W-1:0] dir;
        logic                  lt;
        logic                  one;
    } t_fsd;

    // carried through the radiance dividers
    typedef struct packed {
        logic [DIST_W-1:0]     dist2;
        logic [2:0][DIR_W-1:0] dir;
        logic [2:0]            sat;
    } t_rsd;

endpackage

/* src/srs_div.sv */
// ----------------------------------------------------------------------------
// srs_div
// pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels alongside; the caller guarantees the quotient fits in QW bits
// ----------------------------------------------------------------------------
module srs_div #(
    parameter int NW = 45,
    parameter int DW = 31,
    parameter int QW = 15,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_low  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [SW-1:0] r_side [QW];
    logic          r_vld  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_st
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quo_in;
        logic [SW-1:0] side_in;
        logic          vld_in;
        logic [DW:0]   trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in  = DW'(i_num >> QW);
            assign low_in  = i_num[QW-1:0];
            assign quo_in  = '0;
            assign den_in  = i_den;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign low_in  = r_low[k-1];
            assign quo_in  = r_quo[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
            assign vld_in  = r_vld[k-1];
        end

        // bring down one numerator bit and try the subtract
        assign trial = {rem_in, low_in[QW-1]};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
                r_low[k]  <= low_in << 1;
                r_quo[k]  <= (quo_in << 1) | QW'(ge);
                r_den[k]  <= den_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

/* src/spotlight_radiance_sample.sv */
// ----------------------------------------------------------------------------
// spotlight_radiance_sample
// spotlight incident radiance, unless stalled at the output, for one shading point per cycle
// ----------------------------------------------------------------------------
// Each request carries a shading point; the block returns the unit direction
// toward the light, the quartic-falloff RGB radiance saturated to Q16.16 and a
// flag for a point on the light. One request enters per cycle unless the
// whole pipeline stalls, which it does while a result waits at the output.
// Results pass stages a to c (difference, squared distance), 31 square-root
// stages, 15 direction, 17 falloff and 32 radiance divider stages, then the
// multiply, compare and output register stages. Registers are written through
// the configuration channel, which is always ready; the user must write them
// only while no request is in flight, as the block does not enforce this.
// ----------------------------------------------------------------------------
module spotlight_radiance_sample
    import srs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // ref_x, ref_y, ref_z from the lowest bit
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // dir_x, dir_y, dir_z, radiance_r, radiance_g, radiance_b from the lowest bit
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // zero_distance
    output logic                   m_axis_tuser,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // configuration registers
    logic [POS_W-1:0]      r_light_pos [3];
    logic [CFG_DATA_W-1:0] r_spot_axis;
    logic [CFG_DATA_W-1:0] r_intensity;
    logic [COS_W-1:0]      r_cos_total;
    logic [COS_W-1:0]      r_cos_start;

    logic w_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_pos[0] <= '0;
            r_light_pos[1] <= '0;
            r_light_pos[2] <= '0;
            r_spot_axis    <= CFG_DATA_W'(16384);
            r_intensity    <= '0;
            r_cos_total    <= COS_W'(16384);
            r_cos_start    <= COS_W'(16384);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LIGHT_POS_X:     r_light_pos[0] <= i_cfg_data[POS_W-1:0];
                CFG_LIGHT_POS_Y:     r_light_pos[1] <= i_cfg_data[POS_W-1:0];
                CFG_LIGHT_POS_Z:     r_light_pos[2] <= i_cfg_data[POS_W-1:0];
                CFG_SPOT_AXIS:       r_spot_axis    <= i_cfg_data;
                CFG_INTENSITY_RGB:   r_intensity    <= i_cfg_data;
                CFG_COS_TOTAL_WIDTH: r_cos_total    <= i_cfg_data[COS_W-1:0];
                CFG_COS_FALLOFF:     r_cos_start    <= i_cfg_data[COS_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advances whenever the output register is free or being taken
    logic r_o_vld;

    assign w_en          = !r_o_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    // stage a: light minus point
    logic signed [D_W-1:0] r_a_d [3];
    logic                  r_a_vld;
    logic [POS_W-1:0]      w_ref [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ref[i] = s_axis_tdata[POS_W*i +: POS_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_a_d[i] <= {r_light_pos[i][POS_W-1], r_light_pos[i]}
                          - {w_ref[i][POS_W-1], w_ref[i]};
            end
        end
    end

    // stage b: squares and magnitudes
    logic signed [2*D_W-1:0] w_sq [3];
    logic [SQ_W-1:0]         r_b_sq  [3];
    logic [MAG_W-1:0]        r_b_mag [3];
    logic [2:0]              r_b_neg;
    logic                    r_b_vld;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sq[i] = r_a_d[i] * r_a_d[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_b_sq[i]  <= w_sq[i][SQ_W-1:0];
                r_b_mag[i] <= r_a_d[i][D_W-1] ? MAG_W'(-r_a_d[i]) : r_a_d[i][MAG_W-1:0];
                r_b_neg[i] <= r_a_d[i][D_W-1];
            end
        end
    end

    // stage c: squared distance
    t_geo r_c_geo;
    logic r_c_vld;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_geo.dist2 <= DIST_W'(r_b_sq[0]) + DIST_W'(r_b_sq[1]) + DIST_W'(r_b_sq[2]);
            for (int i = 0; i < 3; i++) begin
                r_c_geo.mag[i] <= r_b_mag[i];
            end
            r_c_geo.neg <= r_b_neg;
        end
    end

    // square root of dist2 * 4096, one root bit per stage
    logic [SQ_REM_W-1:0] r_sq_rem  [SQ_STEPS];
    logic [LEN_W-1:0]    r_sq_root [SQ_STEPS];
    t_geo                r_sq_geo  [SQ_STEPS];
    logic                r_sq_vld  [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam int XB = 2 * (SQ_STEPS - 1 - k) - 12;
        logic [SQ_REM_W-1:0] rem_in;
        logic [LEN_W-1:0]    root_in;
        t_geo                geo_in;
        logic                vld_in;
        logic [1:0]          xb;
        logic [SQ_REM_W+1:0] cur;
        logic [SQ_REM_W+1:0] trial;
        logic                ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign geo_in  = r_c_geo;
            assign vld_in  = r_c_vld;
        end else begin : g_next
            assign rem_in  = r_sq_rem[k-1];
            assign root_in = r_sq_root[k-1];
            assign geo_in  = r_sq_geo[k-1];
            assign vld_in  = r_sq_vld[k-1];
        end

        // next two radicand bits, the low twelve are zero
        if (XB >= 0) begin : g_bits
            assign xb = geo_in.dist2[XB+1:XB];
        end else begin : g_zero
            assign xb = 2'b00;
        end

        assign cur   = {rem_in, xb};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = cur >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k] <= 1'b0;
            end else if (w_en) begin
                r_sq_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_rem[k]  <= ge ? SQ_REM_W'(cur - trial) : cur[SQ_REM_W-1:0];
                r_sq_root[k] <= {root_in[LEN_W-2:0], ge};
                r_sq_geo[k]  <= geo_in;
            end
        end
    end

    // stage e: direction numerators and clamp detection
    logic [LEN_W-1:0]  w_len;
    t_geo              w_geo;
    logic [DNUM_W-1:0] w_dnum [3];
    logic [DNUM_W-1:0] r_e_num [3];
    logic [LEN_W-1:0]  r_e_len;
    t_dsd              r_e_side;
    logic              r_e_vld;

    assign w_len = r_sq_root[SQ_STEPS-1];
    assign w_geo = r_sq_geo[SQ_STEPS-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_dnum[i] = {w_geo.mag[i], 20'b0} + DNUM_W'(w_len >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_e_num[i]      <= w_dnum[i];
                r_e_side.sat[i] <= {1'b0, w_dnum[i]} >= {w_len, 15'b0};
            end
            r_e_len        <= w_len;
            r_e_side.dist2 <= w_geo.dist2;
            r_e_side.neg   <= w_geo.neg;
        end
    end

    // direction dividers
    logic [DQ_W-1:0] w_dq      [3];
    logic            w_dq_vld  [3];
    t_dsd            w_dq_side [3];

    for (genvar i = 0; i < 3; i++) begin : g_ddiv
        srs_div #(
            .NW(DNUM_W),
            .DW(LEN_W),
            .QW(DQ_W),
            .SW($bits(t_dsd))
        ) u_div_dir (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_valid(r_e_vld),
            .i_num  (r_e_num[i]),
            .i_den  (r_e_len),
            .i_side (r_e_side),
            .o_valid(w_dq_vld[i]),
            .o_quo  (w_dq[i]),
            .o_side (w_dq_side[i])
        );
    end

    // stage f: clamp and sign the direction
    logic [DIR_W-1:0]        w_dmag [3];
    logic signed [DIR_W-1:0] r_f_dir [3];
    logic [DIST_W-1:0]       r_f_dist2;
    logic                    r_f_vld;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_dq_side[0].sat[i] || DIR_W'(w_dq[i]) > DIR_ONE) begin
                w_dmag[i] = DIR_ONE;
            end else begin
                w_dmag[i] = DIR_W'(w_dq[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_f_dir[i] <= w_dq_side[0].neg[i] ? -w_dmag[i] : w_dmag[i];
            end
            r_f_dist2 <= w_dq_side[0].dist2;
        end
    end

    // stage g: axis times reversed direction
    logic signed [DIR_W:0]     w_ndir [3];
    logic signed [2*DIR_W:0]   r_g_p   [3];
    logic signed [DIR_W-1:0]   r_g_dir [3];
    logic [DIST_W-1:0]         r_g_dist2;
    logic                      r_g_vld;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ndir[i] = -{r_f_dir[i][DIR_W-1], r_f_dir[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_g_p[i]   <= $signed(r_spot_axis[CH_W*i +: CH_W]) * w_ndir[i];
                r_g_dir[i] <= r_f_dir[i];
            end
            r_g_dist2 <= r_f_dist2;
        end
    end

    // stage h: rounded cosine
    logic signed [2*DIR_W+2:0] w_dot;
    logic signed [C_W-1:0]     r_h_c;
    logic signed [DIR_W-1:0]   r_h_dir [3];
    logic [DIST_W-1:0]         r_h_dist2;
    logic                      r_h_vld;

    assign w_dot = (2*DIR_W+3)'(r_g_p[0]) + (2*DIR_W+3)'(r_g_p[1])
                 + (2*DIR_W+3)'(r_g_p[2]) + (2*DIR_W+3)'(8192);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_c     <= w_dot[2*DIR_W+2:14];
            r_h_dir   <= r_g_dir;
            r_h_dist2 <= r_g_dist2;
        end
    end

    // stage i: cone tests and falloff division setup
    logic signed [COS_W:0]  w_fden;
    logic signed [C_W-1:0]  w_ctw;
    logic signed [C_W-1:0]  w_cfs;
    logic signed [C_W-1:0]  w_fa;
    logic [FNUM_W-1:0]      r_i_num;
    logic [FDEN_W-1:0]      r_i_den;
    t_fsd                   r_i_side;
    logic                   r_i_vld;

    assign w_ctw  = C_W'($signed(r_cos_total));
    assign w_cfs  = C_W'($signed(r_cos_start));
    assign w_fden = {r_cos_start[COS_W-1], r_cos_start} - {r_cos_total[COS_W-1], r_cos_total};
    assign w_fa   = r_h_c - w_ctw;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_i_num        <= {w_fa[15:0], 16'b0};
            r_i_den        <= w_fden[FDEN_W-1:0];
            r_i_side.lt    <= r_h_c < w_ctw;
            r_i_side.one   <= (r_h_c > w_cfs) || (w_fden <= 17'sd0);
            r_i_side.dist2 <= r_h_dist2;
            for (int i = 0; i < 3; i++) begin
                r_i_side.dir[i] <= r_h_dir[i];
            end
        end
    end

    // falloff divider
    logic [FQ_W-1:0] w_t;
    logic            w_t_vld;
    t_fsd            w_t_side;

    srs_div #(
        .NW(FNUM_W),
        .DW(FDEN_W),
        .QW(FQ_W),
        .SW($bits(t_fsd))
    ) u_div_fall (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(r_i_vld),
        .i_num  (r_i_num),
        .i_den  (r_i_den),
        .i_side (r_i_side),
        .o_valid(w_t_vld),
        .o_quo  (w_t),
        .o_side (w_t_side)
    );

    // stage j: first squaring
    logic [2*FQ_W-1:0] w_t2;
    logic [FQ_W-1:0]   r_j_u;
    t_fsd              r_j_side;
    logic              r_j_vld;

    assign w_t2 = w_t * w_t;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_j_u    <= FQ_W'((w_t2 + (2*FQ_W)'(32768)) >> 16);
            r_j_side <= w_t_side;
        end
    end

    // stage k: second squaring and cone select
    logic [2*FQ_W-1:0] w_u2;
    logic [FQ_W-1:0]   r_k_f;
    t_fsd              r_k_side;
    logic              r_k_vld;

    assign w_u2 = r_j_u * r_j_u;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_j_side.lt) begin
                r_k_f <= '0;
            end else if (r_j_side.one) begin
                r_k_f <= FALL_ONE;
            end else begin
                r_k_f <= FQ_W'((w_u2 + (2*FQ_W)'(32768)) >> 16);
            end
            r_k_side <= r_j_side;
        end
    end

    // stage l: intensity times falloff
    logic [CH_W+FQ_W-1:0] r_l_p [3];
    t_fsd                 r_l_side;
    logic                 r_l_vld;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_l_p[i] <= {{FQ_W{1'b0}}, r_intensity[CH_W*i +: CH_W]}
                          * {{CH_W{1'b0}}, r_k_f};
            end
            r_l_side <= r_k_side;
        end
    end

    // stage m: rounded numerators and saturation detection
    logic [RNUM_W-1:0] w_rx [3];
    logic [RNUM_W-1:0] r_m_x [3];
    logic [DIST_W-1:0] r_m_dist2;
    t_rsd              r_m_side;
    logic              r_m_vld;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rx[i] = RNUM_W'({r_l_p[i], 8'b0}) + RNUM_W'(r_l_side.dist2 >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_m_x[i]        <= w_rx[i];
                r_m_side.sat[i] <= DIST_W'(w_rx[i][RNUM_W-1:RAD_W]) >= r_l_side.dist2;
            end
            r_m_dist2      <= r_l_side.dist2;
            r_m_side.dist2 <= r_l_side.dist2;
            r_m_side.dir   <= r_l_side.dir;
        end
    end

    // radiance dividers
    logic [RAD_W-1:0] w_rq      [3];
    logic             w_rq_vld  [3];
    t_rsd             w_rq_side [3];

    for (genvar i = 0; i < 3; i++) begin : g_rdiv
        srs_div #(
            .NW(RNUM_W),
            .DW(DIST_W),
            .QW(RAD_W),
            .SW($bits(t_rsd))
        ) u_div_rad (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_valid(r_m_vld),
            .i_num  (r_m_x[i]),
            .i_den  (r_m_dist2),
            .i_side (r_m_side),
            .o_valid(w_rq_vld[i]),
            .o_quo  (w_rq[i]),
            .o_side (w_rq_side[i])
        );
    end

    // output register with zero distance and saturation
    logic                   w_zero;
    logic [OUT_TDATA_W-1:0] r_o_data;
    logic                   r_o_user;

    assign w_zero = w_rq_side[0].dist2 == '0;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_o_data[DIR_W*i +: DIR_W] <= w_zero ? '0 : w_rq_side[0].dir[i];
                if (w_zero) begin
                    r_o_data[3*DIR_W + RAD_W*i +: RAD_W] <= '0;
                end else if (w_rq_side[0].sat[i]) begin
                    r_o_data[3*DIR_W + RAD_W*i +: RAD_W] <= '1;
                end else begin
                    r_o_data[3*DIR_W + RAD_W*i +: RAD_W] <= w_rq[i];
                end
            end
            r_o_user <= w_zero;
        end
    end

    // valid bits of the plain stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
            r_i_vld <= 1'b0;
            r_j_vld <= 1'b0;
            r_k_vld <= 1'b0;
            r_l_vld <= 1'b0;
            r_m_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= s_axis_tvalid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_e_vld <= r_sq_vld[SQ_STEPS-1];
            r_f_vld <= w_dq_vld[0];
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
            r_i_vld <= r_h_vld;
            r_j_vld <= w_t_vld;
            r_k_vld <= r_j_vld;
            r_l_vld <= r_k_vld;
            r_m_vld <= r_l_vld;
            r_o_vld <= w_rq_vld[0];
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_user;

endmodule

/* src/srs_chk.sv */
// ----------------------------------------------------------------------------
// srs_chk
// port-level checks of the spotlight radiance sampler
// ----------------------------------------------------------------------------
module srs_chk
    import srs_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // an empty output register never blocks new requests
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // a point on the light gives all zero fields
    a_zero_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("zero distance with nonzero fields");

    // direction components stay within the unit range
    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ($signed(m_axis_tdata[15:0]) >= -16384 && $signed(m_axis_tdata[15:0]) <= 16384)
            && ($signed(m_axis_tdata[31:16]) >= -16384
                && $signed(m_axis_tdata[31:16]) <= 16384)
            && ($signed(m_axis_tdata[47:32]) >= -16384
                && $signed(m_axis_tdata[47:32]) <= 16384))
        else $error("direction out of range");

endmodule

bind spotlight_radiance_sample srs_chk u_srs_chk (.*);

/* dv/spotlight_radiance_sample_tb.sv */
// ----------------------------------------------------------------------------
// spotlight_radiance_sample_tb
// self-checking bench for the spotlight radiance sampler
// ----------------------------------------------------------------------------
// Drives shading points through the request stream under several register
// settings and idle patterns, predicts direction, radiance and the zero
// distance flag with an exact integer model and compares every result field.
// ----------------------------------------------------------------------------
module spotlight_radiance_sample_tb;
    import srs_pkg::*;

    localparam int LATENCY = 108;
    localparam longint CYCLE_LIMIT = 1500000;
    // index past the last register, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic                  zero;
        logic [2:0][RAD_W-1:0] rad;
        logic [2:0][DIR_W-1:0] dir;
    } t_sample;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // shadow registers
    logic signed [POS_W-1:0] lp [3];
    logic [47:0]             axis_reg;
    logic [47:0]             inten_reg;
    logic signed [COS_W-1:0] ctw_reg;
    logic signed [COS_W-1:0] cfs_reg;

    t_sample pending_samples [$];
    int      errors = 0;
    longint  cycles = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_off = 0;

    spotlight_radiance_sample dut (.*);

    always #10 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("spotlight_radiance_sample_tb: errors");
            $finish;
        end
    end

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // expected output for one shading point
    function automatic t_sample light_sample(logic [IN_TDATA_W-1:0] pt);
        t_sample s;
        longint d [3];
        longint dv [3];
        longint unsigned dist2, len, mag, v, fall, q;
        longint dot, c, y, ctw, cfs;
        longint unsigned t, u;
        s = '0;
        dist2 = 0;
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'(lp[i]) - longint'($signed(pt[i*POS_W +: POS_W]));
            dist2 += d[i] * d[i];
        end
        if (dist2 == 0) begin
            s.zero = 1'b1;
            return s;
        end
        len = root_floor(dist2 << 12);
        if (len == 0) len = 1;
        for (int i = 0; i < 3; i++) begin
            mag = d[i] < 0 ? -d[i] : d[i];
            v = ((mag << 20) + (len >> 1)) / len;
            if (v > 16384) v = 16384;
            dv[i] = d[i] < 0 ? -longint'(v) : longint'(v);
            s.dir[i] = dv[i][15:0];
            dot += longint'($signed(axis_reg[i*16 +: 16])) * (-dv[i]);
        end
        // rounded shift that floors for negative sums
        y = dot + 8192;
        c = y >= 0 ? (y >>> 14) : -((-y + 16383) >>> 14);
        ctw = ctw_reg;
        cfs = cfs_reg;
        if (c < ctw) begin
            fall = 0;
        end else if (c > cfs || cfs - ctw <= 0) begin
            fall = 65536;
        end else begin
            t = (unsigned'(c - ctw) << 16) / unsigned'(cfs - ctw);
            u = (t * t + 32768) >> 16;
            fall = (u * u + 32768) >> 16;
        end
        for (int i = 0; i < 3; i++) begin
            q = ((64'(inten_reg[i*16 +: 16]) * fall << 8)
                 + (dist2 >> 1)) / dist2;
            s.rad[i] = q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
        end
        return s;
    endfunction

    // one register write, with the valid dropped again before the task returns
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_LIGHT_POS_X:     lp[0] = val[23:0];
            CFG_LIGHT_POS_Y:     lp[1] = val[23:0];
            CFG_LIGHT_POS_Z:     lp[2] = val[23:0];
            CFG_SPOT_AXIS:       axis_reg = val;
            CFG_INTENSITY_RGB:   inten_reg = val;
            CFG_COS_TOTAL_WIDTH: ctw_reg = val[15:0];
            CFG_COS_FALLOFF:     cfs_reg = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // stop offering requests and wait for every result
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_samples.size() != 0);
    endtask

    // one request, expected result queued at acceptance; valid stays high
    task automatic send_item(logic [IN_TDATA_W-1:0] pt, bit known, t_sample res);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pt;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_samples.push_back(known ? res : light_sample(pt));
    endtask

    task automatic send_point(logic [IN_TDATA_W-1:0] pt);
        send_item(pt, 1'b0, '0);
    endtask

    // back to back requests with no idling
    task automatic send_burst(int n);
        logic [IN_TDATA_W-1:0] pt;
        for (int k = 0; k < n; k++) begin
            pt = near_point();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= pt;
            do @(posedge i_clk); while (!s_axis_tready);
            pending_samples.push_back(light_sample(pt));
        end
    endtask

    // mostly points near the light so the radiance is not tiny
    function automatic logic [IN_TDATA_W-1:0] near_point();
        logic [IN_TDATA_W-1:0] pt;
        int span;
        span = 1 << $urandom_range(20, 2);
        for (int i = 0; i < 3; i++) begin
            if ($urandom_range(9) == 0)
                pt[i*POS_W +: POS_W] = POS_W'($urandom);
            else
                pt[i*POS_W +: POS_W] = POS_W'(lp[i] + ($urandom_range(2*span) - span));
        end
        return pt;
    endfunction

    function automatic logic [15:0] rand_cos();
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    // receiver ready with random stalls and a long hold-off
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else if (i_rst_n) begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_samples.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                errors++;
            end else begin
                t_sample e;
                e = pending_samples.pop_front();
                for (int i = 0; i < 3; i++) begin
                    if (m_axis_tdata[i*DIR_W +: DIR_W] !== e.dir[i]) begin
                        $error("dir[%0d] expected %h actual %h", i, e.dir[i],
                               m_axis_tdata[i*DIR_W +: DIR_W]);
                        errors++;
                    end
                    if (m_axis_tdata[3*DIR_W + i*RAD_W +: RAD_W] !== e.rad[i]) begin
                        $error("radiance[%0d] expected %h actual %h", i, e.rad[i],
                               m_axis_tdata[3*DIR_W + i*RAD_W +: RAD_W]);
                        errors++;
                    end
                end
                if (m_axis_tuser !== e.zero) begin
                    $error("zero_distance expected %b actual %b", e.zero, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // directed points: ref xyz, with the known result where obvious
    typedef struct {
        logic [23:0] x, y, z;
        bit          known;
        t_sample     res;
    } t_row;

    t_row rows [12];

    initial begin
        t_sample zero_hit;
        zero_hit = '0;
        zero_hit.zero = 1'b1;
        rows[0]  = '{24'd0, 24'd0, 24'd0, 1, zero_hit};
        rows[1]  = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0, '0};
        rows[2]  = '{24'h800000, 24'h800000, 24'h800000, 0, '0};
        rows[3]  = '{24'h7FFFFF, 24'h800000, 24'h000000, 0, '0};
        rows[4]  = '{24'hFFFFFF, 24'd0, 24'd0, 0, '0};
        rows[5]  = '{24'd1, 24'd0, 24'd0, 0, '0};
        rows[6]  = '{24'd0, 24'hFFFF00, 24'd0, 0, '0};
        rows[7]  = '{24'd0, 24'd0, 24'd256, 0, '0};
        rows[8]  = '{24'h000100, 24'h000100, 24'h000100, 0, '0};
        rows[9]  = '{24'h800000, 24'd0, 24'd0, 0, '0};
        rows[10] = '{24'hAAAAAA, 24'h555555, 24'hF0F0F0, 0, '0};
        rows[11] = '{24'h0F0F0F, 24'hC3C3C3, 24'h3C3C3C, 0, '0};
    end

    // stimulus
    initial begin
        logic [47:0] ax;
        lp[0] = 0; lp[1] = 0; lp[2] = 0;
        axis_reg = 48'd16384; inten_reg = '0;
        ctw_reg = 16'sd16384; cfs_reg = 16'sd16384;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at reset settings then at full intensity
        for (int pass = 0; pass < 2; pass++) begin
            for (int r = 0; r < 12; r++) begin
                send_item({rows[r].z, rows[r].y, rows[r].x}, rows[r].known, rows[r].res);
            end
            wait_drained();
            repeat (LATENCY) @(posedge i_clk);
            write_reg(CFG_INTENSITY_RGB, 48'hFFFF_FFFF_FFFF);
            write_reg(CFG_COS_TOTAL_WIDTH, 16'hC000);
            write_reg(CFG_COS_FALLOFF, 16'h2000);
            write_reg(CFG_UNMAPPED, 48'h1234);
        end

        // random phases, each under a fresh setting
        for (int ph = 0; ph < 16; ph++) begin
            wait_drained();
            repeat (LATENCY) @(posedge i_clk);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            for (int i = 0; i < 3; i++)
                write_reg(CFG_IDX_W'(CFG_LIGHT_POS_X + i), ph == 3 ? 48'h7FFFFF :
                          ph == 4 ? 48'h800000 : 48'($urandom));
            case (ph % 3)
                0: ax = {16'd0, 16'd0, 16'hC000};
                1: ax = {16'd16384, 16'd0, 16'd0};
                default: ax = {rand_cos(), rand_cos(), rand_cos()};
            endcase
            write_reg(CFG_SPOT_AXIS, ph == 5 ? 48'hFFFF_FFFF_FFFF : ax);
            write_reg(CFG_INTENSITY_RGB, ph == 6 ? 48'd0 :
                      ph == 7 ? 48'hFFFF_FFFF_FFFF : {16'($urandom), 32'($urandom)});
            write_reg(CFG_COS_TOTAL_WIDTH, ph == 8 ? 16'hC000 :
                      ph == 9 ? 16'h4000 : rand_cos());
            write_reg(CFG_COS_FALLOFF, ph == 8 ? 16'h4000 :
                      ph == 9 ? 16'hC000 : ph == 10 ? ctw_reg : rand_cos());
            if (ph == 2) begin
                // long receiver hold-off while requests keep coming
                hold_off = 400;
                send_burst(150);
            end
            for (int k = 0; k < 75; k++) begin
                if (k % 25 == 0) begin
                    send_point({lp[2], lp[1], lp[0]});
                    wait_drained();
                end else begin
                    send_point(near_point());
                end
            end
        end

        wait_drained();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (errors == 0)
            $display("spotlight_radiance_sample_tb: clean");
        else
            $display("spotlight_radiance_sample_tb: errors");
        $finish;
    end

endmodule

/* files.f */
src/srs_pkg.sv
src/srs_div.sv
src/spotlight_radiance_sample.sv
src/srs_chk.sv
dv/spotlight_radiance_sample_tb.sv
